[rtl/odi_pkg.sv]
// shared types, constants and tables for the odometry integrator
`default_nettype none
package odi_pkg;

    localparam int MAX_BATCH    = 256;
    localparam int CORDIC_STEPS = 16;
    localparam int DIV_W        = 48;
    localparam int DEN_W        = 30;
    localparam int CRD_W        = 34;
    localparam int SUM_W        = 24;
    localparam int CNT_W        = 9;
    localparam int CFG_W        = 15;

    localparam logic [23:0]      ANG_SCALE   = 24'd11199533;
    localparam logic [CRD_W-1:0] CORDIC_GAIN = 34'd652032874;
    localparam logic [DEN_W-1:0] DIST_DEN    = 30'd62500;
    // floor(2^40 / 62500)
    localparam logic [24:0]      DIST_RECIP  = 25'd17592186;

    localparam logic [1:0] CFG_MODE  = 2'd0;
    localparam logic [1:0] CFG_BATCH = 2'd1;
    localparam logic [1:0] CFG_THR   = 2'd2;

    localparam logic [1:0] MODE_EULER = 2'd0;
    localparam logic [1:0] MODE_RK    = 2'd1;
    localparam logic [1:0] MODE_EXACT = 2'd2;

    typedef struct packed {
        logic [SUM_W-1:0] lin_sum;
        logic [SUM_W-1:0] ang_sum;
        logic [SUM_W-1:0] time_sum;
        logic [CNT_W-1:0] count;
    } t_job;

    typedef struct packed {
        logic [31:0] pose_x;
        logic [31:0] pose_y;
        logic [15:0] heading;
        logic [15:0] mean_linear;
        logic [15:0] mean_angular;
    } t_result;

    typedef struct packed {
        logic busy;
        logic load;
    } t_back_stat;

    function automatic logic [31:0] atan_entry(input logic [4:0] idx);
        logic [31:0] r;
        begin
            case (idx)
                5'd0:  r = 32'h20000000;
                5'd1:  r = 32'h12E4051E;
                5'd2:  r = 32'h09FB385B;
                5'd3:  r = 32'h051111D4;
                5'd4:  r = 32'h028B0D43;
                5'd5:  r = 32'h0145D7E1;
                5'd6:  r = 32'h00A2F61E;
                5'd7:  r = 32'h00517C55;
                5'd8:  r = 32'h0028BE53;
                5'd9:  r = 32'h00145F2F;
                5'd10: r = 32'h000A2F98;
                5'd11: r = 32'h000517CC;
                5'd12: r = 32'h00028BE6;
                5'd13: r = 32'h000145F3;
                5'd14: r = 32'h0000A2FA;
                5'd15: r = 32'h0000517D;
                5'd16: r = 32'h000028BE;
                5'd17: r = 32'h0000145F;
                5'd18: r = 32'h00000A30;
                5'd19: r = 32'h00000518;
                5'd20: r = 32'h0000028C;
                5'd21: r = 32'h00000146;
                5'd22: r = 32'h000000A3;
                5'd23: r = 32'h00000051;
                5'd24: r = 32'h00000029;
                5'd25: r = 32'h00000014;
                5'd26: r = 32'h0000000A;
                5'd27: r = 32'h00000005;
                5'd28: r = 32'h00000003;
                5'd29: r = 32'h00000001;
                5'd30: r = 32'h00000001;
                default: r = 32'h00000000;
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

[rtl/odi_fifo.sv]
// two-entry job queue between front and back
`default_nettype none
module odi_fifo (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  odi_pkg::t_job    i_job,
    output logic             o_full,
    input  wire              i_pop,
    output logic             o_valid,
    output odi_pkg::t_job    o_job
);
    import odi_pkg::*;

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       do_push, do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end
endmodule
`default_nettype wire

[rtl/odi_div.sv]
// restoring divider, one quotient bit per cycle
`default_nettype none
module odi_div (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_start,
    input  wire [odi_pkg::DIV_W-1:0]        i_num,
    input  wire [odi_pkg::DEN_W-1:0]        i_den,
    output logic                            o_busy,
    output logic [odi_pkg::DIV_W-1:0]       o_quo
);
    import odi_pkg::*;

    logic [DIV_W-1:0] r_quo;
    logic [DEN_W-1:0] r_rem, r_den;
    logic [5:0]       r_cnt;
    logic             r_busy;
    logic [DEN_W:0]   trial;
    logic             fits;

    assign trial  = {r_rem, r_quo[DIV_W-1]};
    assign fits   = (trial >= {1'b0, r_den});
    assign o_busy = r_busy;
    assign o_quo  = r_quo;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= fits ? DEN_W'(trial - {1'b0, r_den}) : trial[DEN_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 6'd1;
            if (r_cnt == 6'(DIV_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

[rtl/odi_cordic.sv]
// rotation-mode cordic, one iteration per cycle, sin and cos in q4.30
`default_nettype none
module odi_cordic (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_start,
    input  wire [31:0]                          i_angle,
    output logic                                o_busy,
    output logic signed [odi_pkg::CRD_W-1:0]    o_sin,
    output logic signed [odi_pkg::CRD_W-1:0]    o_cos
);
    import odi_pkg::*;

    logic signed [CRD_W-1:0] r_x, r_y, r_z;
    logic                    r_flip, r_busy;
    logic [4:0]              r_i;
    logic                    flip;
    logic [31:0]             folded;
    logic signed [CRD_W-1:0] xs, ys, at;

    assign flip   = 32'(i_angle + 32'h40000000) >> 31 != 32'd0;
    assign folded = flip ? (i_angle ^ 32'h80000000) : i_angle;
    assign xs     = r_x >>> r_i;
    assign ys     = r_y >>> r_i;
    assign at     = CRD_W'(atan_entry(r_i));
    assign o_busy = r_busy;
    assign o_sin  = r_flip ? -r_y : r_y;
    assign o_cos  = r_flip ? -r_x : r_x;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= CORDIC_GAIN;
            r_y    <= '0;
            r_z    <= CRD_W'(signed'(folded));
            r_flip <= flip;
        end else if (r_busy) begin
            if (!r_z[CRD_W-1]) begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - at;
            end else begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + at;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_i    <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_i    <= '0;
        end else if (r_busy) begin
            r_i <= r_i + 5'd1;
            if (r_i == 5'(CORDIC_STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

[rtl/odi_front.sv]
// sample accumulation and batch framing
`default_nettype none
module odi_front (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_push,
    input  wire signed [15:0]               i_linear_velocity,
    input  wire signed [15:0]               i_angular_velocity,
    input  wire [15:0]                      i_elapsed_us,
    input  wire [odi_pkg::CNT_W-1:0]        i_batch_count,
    input  wire                             i_q_full,
    output logic                            o_q_push,
    output odi_pkg::t_job                   o_job
);
    import odi_pkg::*;

    logic [SUM_W-1:0] r_lin, r_ang, r_time;
    logic [CNT_W-1:0] r_cnt;
    logic [SUM_W-1:0] n_lin, n_ang, n_time;
    logic [CNT_W-1:0] n_cnt, limit;
    logic             take, fire;

    always_comb begin
        if (i_batch_count == '0) begin
            limit = CNT_W'(1);
        end else if (i_batch_count > CNT_W'(MAX_BATCH)) begin
            limit = CNT_W'(MAX_BATCH);
        end else begin
            limit = i_batch_count;
        end
    end

    assign take   = i_push && !i_q_full;
    assign n_lin  = r_lin + SUM_W'(i_linear_velocity);
    assign n_ang  = r_ang + SUM_W'(i_angular_velocity);
    assign n_time = r_time + SUM_W'(i_elapsed_us);
    assign n_cnt  = r_cnt + CNT_W'(1);
    assign fire   = (n_cnt >= limit);

    assign o_q_push       = take && fire;
    assign o_job.lin_sum  = n_lin;
    assign o_job.ang_sum  = n_ang;
    assign o_job.time_sum = n_time;
    assign o_job.count    = n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lin  <= '0;
            r_ang  <= '0;
            r_time <= '0;
            r_cnt  <= '0;
        end else if (take) begin
            if (fire) begin
                r_lin  <= '0;
                r_ang  <= '0;
                r_time <= '0;
                r_cnt  <= '0;
            end else begin
                r_lin  <= n_lin;
                r_ang  <= n_ang;
                r_time <= n_time;
                r_cnt  <= n_cnt;
            end
        end
    end
endmodule
`default_nettype wire

[rtl/odi_back.sv]
// batch averaging and pose update sequencer with result slot
`default_nettype none
module odi_back (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_job_valid,
    input  odi_pkg::t_job                   i_job,
    output logic                            o_job_pop,
    input  wire [1:0]                       i_mode,
    input  wire [odi_pkg::CFG_W-1:0]        i_threshold,
    input  wire                             i_res_pop,
    output logic                            o_res_valid,
    output odi_pkg::t_result                o_res,
    output odi_pkg::t_back_stat             o_stat
);
    import odi_pkg::*;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_MEAN  = 5'd1;
    localparam logic [4:0] S_ANG0  = 5'd2;
    localparam logic [4:0] S_ANG1  = 5'd3;
    localparam logic [4:0] S_ANG2  = 5'd4;
    localparam logic [4:0] S_ANG3  = 5'd5;
    localparam logic [4:0] S_LWAIT = 5'd6;
    localparam logic [4:0] S_LMUL  = 5'd7;
    localparam logic [4:0] S_LUPD  = 5'd8;
    localparam logic [4:0] S_EC0   = 5'd9;
    localparam logic [4:0] S_EC1   = 5'd10;
    localparam logic [4:0] S_EDIF  = 5'd11;
    localparam logic [4:0] S_EMUL  = 5'd12;
    localparam logic [4:0] S_EDIV  = 5'd13;
    localparam logic [4:0] S_EWAIT = 5'd14;
    localparam logic [4:0] S_EUPD  = 5'd15;
    localparam logic [4:0] S_OUT   = 5'd16;
    localparam logic [4:0] S_LR0   = 5'd17;
    localparam logic [4:0] S_LR1   = 5'd18;
    localparam logic [4:0] S_LR2   = 5'd19;
    localparam logic [4:0] S_LR3   = 5'd20;

    logic [4:0]       r_state, n_state;
    logic [31:0]      r_x, r_y, r_yaw;
    logic [SUM_W-1:0] r_t;
    logic             r_ln, r_an;
    logic [15:0]      r_vm, r_wm;
    logic [39:0]      r_vt, r_wt;
    logic [43:0]      r_plo;
    logic [63:0]      r_p;
    logic [31:0]      r_dfull;
    logic [39:0]      r_dn;
    logic [44:0]      r_rlo;
    logic [24:0]      r_rq;
    logic [39:0]      r_rqd;
    logic [23:0]      r_dist;
    logic [56:0]      r_px, r_py;
    logic             r_pxn, r_pyn;
    logic signed [CRD_W-1:0] r_s0, r_c0;
    logic signed [CRD_W:0]   r_dvs, r_dvc;
    logic [DIV_W-1:0] r_nx, r_ny;
    logic             r_nxn, r_nyn;
    logic             r_out_valid;
    t_result          r_out;

    logic [SUM_W-1:0] lmag, amag;
    logic [CNT_W-1:0] half_n;
    logic             div_start;
    logic [DIV_W-1:0] num0, num1;
    logic [DEN_W-1:0] den0, den1;
    logic             d0_busy, d1_busy;
    logic [DIV_W-1:0] q0, q1;
    logic             c_start, c_busy;
    logic [31:0]      c_angle;
    logic signed [CRD_W-1:0] c_sin, c_cos;
    logic [63:0]      pf, ph;
    logic [31:0]      dfull, dhalf;
    logic             exact;
    logic [DEN_W-1:0] wden;
    logic [CRD_W-1:0] cmag, smag;
    logic [CRD_W:0]   dvs_mag, dvc_mag;
    logic [64:0]      rprod;
    logic [39:0]      rrem;
    logic [57:0]      rx, ry;
    logic [31:0]      addx, addy, qx, qy;
    logic             load;

    assign lmag   = i_job.lin_sum[SUM_W-1] ? -i_job.lin_sum : i_job.lin_sum;
    assign amag   = i_job.ang_sum[SUM_W-1] ? -i_job.ang_sum : i_job.ang_sum;
    assign half_n = i_job.count >> 1;
    assign wden   = DEN_W'({r_wm, 14'd0});

    assign pf    = r_p + 64'(1 << 25);
    assign ph    = r_p + 64'(1 << 26);
    assign dfull = r_an ? -pf[57:26] : pf[57:26];
    assign dhalf = r_an ? -ph[58:27] : ph[58:27];
    assign exact = (i_mode == MODE_EXACT) && (r_wm > 16'(i_threshold));

    assign cmag    = c_cos[CRD_W-1] ? CRD_W'(-c_cos) : CRD_W'(c_cos);
    assign smag    = c_sin[CRD_W-1] ? CRD_W'(-c_sin) : CRD_W'(c_sin);
    assign dvs_mag = r_dvs[CRD_W] ? (CRD_W+1)'(-r_dvs) : (CRD_W+1)'(r_dvs);
    assign dvc_mag = r_dvc[CRD_W] ? (CRD_W+1)'(-r_dvc) : (CRD_W+1)'(r_dvc);

    // distance by reciprocal multiply, one correction step
    assign rprod = {45'(r_dn[39:20]) * 45'(DIST_RECIP), 20'd0} + 65'(r_rlo);
    assign rrem  = r_dn - r_rqd;

    assign rx   = {1'b0, r_px} + 58'(1 << 29);
    assign ry   = {1'b0, r_py} + 58'(1 << 29);
    assign addx = r_pxn ? -{4'd0, rx[57:30]} : {4'd0, rx[57:30]};
    assign addy = r_pyn ? -{4'd0, ry[57:30]} : {4'd0, ry[57:30]};
    assign qx   = r_nxn ? -q0[31:0] : q0[31:0];
    assign qy   = r_nyn ? -q1[31:0] : q1[31:0];

    assign o_job_pop   = (r_state == S_IDLE) && i_job_valid;
    assign load        = (r_state == S_OUT) && (!r_out_valid || i_res_pop);
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;
    assign o_stat.busy = (r_state != S_IDLE);
    assign o_stat.load = load;

    always_comb begin
        div_start = 1'b0;
        num0      = '0;
        num1      = '0;
        den0      = DEN_W'(1);
        den1      = DEN_W'(1);
        case (r_state)
            S_IDLE: begin
                div_start = i_job_valid;
                num0      = DIV_W'(lmag) + DIV_W'(half_n);
                num1      = DIV_W'(amag) + DIV_W'(half_n);
                den0      = DEN_W'(i_job.count);
                den1      = DEN_W'(i_job.count);
            end
            S_EDIV: begin
                div_start = 1'b1;
                num0      = r_nx + DIV_W'(wden >> 1);
                num1      = r_ny + DIV_W'(wden >> 1);
                den0      = wden;
                den1      = wden;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    always_comb begin
        c_start = 1'b0;
        c_angle = r_yaw;
        case (r_state)
            S_ANG3: begin
                c_start = 1'b1;
                c_angle = (!exact && (i_mode == MODE_RK || i_mode == MODE_EXACT))
                        ? r_yaw + dhalf : r_yaw;
            end
            S_EC0: begin
                c_start = !c_busy;
                c_angle = r_yaw + r_dfull;
            end
            default: begin
                c_start = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_job_valid) n_state = S_MEAN;
            S_MEAN:  if (!d0_busy && !d1_busy) n_state = S_ANG0;
            S_ANG0:  n_state = S_ANG1;
            S_ANG1:  n_state = S_ANG2;
            S_ANG2:  n_state = S_ANG3;
            S_ANG3:  n_state = exact ? S_EC0 : S_LR0;
            S_LR0:   n_state = S_LR1;
            S_LR1:   n_state = S_LR2;
            S_LR2:   n_state = S_LR3;
            S_LR3:   n_state = S_LWAIT;
            S_LWAIT: if (!c_busy) n_state = S_LMUL;
            S_LMUL:  n_state = S_LUPD;
            S_LUPD:  n_state = S_OUT;
            S_EC0:   if (!c_busy) n_state = S_EC1;
            S_EC1:   if (!c_busy) n_state = S_EDIF;
            S_EDIF:  n_state = S_EMUL;
            S_EMUL:  n_state = S_EDIV;
            S_EDIV:  n_state = S_EWAIT;
            S_EWAIT: if (!d0_busy && !d1_busy) n_state = S_EUPD;
            S_EUPD:  n_state = S_OUT;
            S_OUT:   if (load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    odi_div u_div0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num0),
        .i_den   (den0),
        .o_busy  (d0_busy),
        .o_quo   (q0)
    );

    odi_div u_div1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num1),
        .i_den   (den1),
        .o_busy  (d1_busy),
        .o_quo   (q1)
    );

    odi_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (c_start),
        .i_angle (c_angle),
        .o_busy  (c_busy),
        .o_sin   (c_sin),
        .o_cos   (c_cos)
    );

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_t  <= i_job.time_sum;
                r_ln <= i_job.lin_sum[SUM_W-1];
                r_an <= i_job.ang_sum[SUM_W-1];
            end
            S_MEAN: begin
                r_vm <= q0[15:0];
                r_wm <= q1[15:0];
            end
            S_ANG0: begin
                r_vt <= 40'(r_vm) * 40'(r_t);
                r_wt <= 40'(r_wm) * 40'(r_t);
            end
            S_ANG1: begin
                r_plo <= 44'(r_wt[19:0]) * 44'(ANG_SCALE);
            end
            S_ANG2: begin
                r_p <= ({20'd0, 44'(r_wt[39:20]) * 44'(ANG_SCALE)} << 20) + 64'(r_plo);
            end
            S_ANG3: begin
                r_dfull <= dfull;
                r_dn    <= r_vt + 40'(DIST_DEN >> 1);
            end
            S_LR0: begin
                r_rlo <= 45'(r_dn[19:0]) * 45'(DIST_RECIP);
            end
            S_LR1: begin
                r_rq <= rprod[64:40];
            end
            S_LR2: begin
                r_rqd <= 40'(r_rq) * 40'(DIST_DEN);
            end
            S_LR3: begin
                r_dist <= (rrem >= 40'(DIST_DEN)) ? 24'(r_rq + 25'd1) : r_rq[23:0];
            end
            S_LMUL: begin
                r_px  <= 57'(r_dist) * 57'(cmag[32:0]);
                r_py  <= 57'(r_dist) * 57'(smag[32:0]);
                r_pxn <= r_ln ^ c_cos[CRD_W-1];
                r_pyn <= r_ln ^ c_sin[CRD_W-1];
            end
            S_EC0: begin
                r_s0 <= c_sin;
                r_c0 <= c_cos;
            end
            S_EDIF: begin
                r_dvs <= (CRD_W+1)'(c_sin) - (CRD_W+1)'(r_s0);
                r_dvc <= (CRD_W+1)'(r_c0) - (CRD_W+1)'(c_cos);
            end
            S_EMUL: begin
                r_nx  <= DIV_W'(49'(r_vm) * 49'(dvs_mag[32:0]));
                r_ny  <= DIV_W'(49'(r_vm) * 49'(dvc_mag[32:0]));
                r_nxn <= r_ln ^ r_dvs[CRD_W] ^ r_an;
                r_nyn <= r_ln ^ r_dvc[CRD_W] ^ r_an;
            end
            default: begin
            end
        endcase
        if (load) begin
            r_out.pose_x       <= r_x;
            r_out.pose_y       <= r_y;
            r_out.heading      <= r_yaw[31:16];
            r_out.mean_linear  <= r_ln ? -r_vm : r_vm;
            r_out.mean_angular <= r_an ? -r_wm : r_wm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_x         <= '0;
            r_y         <= '0;
            r_yaw       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_LUPD) begin
                r_x   <= r_x + addx;
                r_y   <= r_y + addy;
                r_yaw <= r_yaw + r_dfull;
            end else if (r_state == S_EUPD) begin
                r_x   <= r_x + qx;
                r_y   <= r_y + qy;
                r_yaw <= r_yaw + r_dfull;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_res_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

[rtl/diff_drive_odometry_integrator_core.sv]
// differential drive odometry integrator top level
//
//   channel   direction  handshake                 word
//   sample    in         push / full               linear, angular velocity, elapsed us
//   result    out        empty / pop               pose x, y, heading, means
//   config    in         i_cfg_valid / o_cfg_ready register index and data
//
// a sample that does not close a batch is only added to the running sums in the front
// a closing batch goes from job pop to result in the back (euler, runge-kutta or exact arc)
// and waits there on the 48-step serial dividers and the 16-step cordic
// two closed batches can wait in the queue; full rises only when it holds both
// reset is synchronous and clears pose, sums and configuration to defaults
`default_nettype none
module diff_drive_odometry_integrator_core (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          push,
    output logic                         full,
    input  wire signed [15:0]            i_linear_velocity,
    input  wire signed [15:0]            i_angular_velocity,
    input  wire [15:0]                   i_elapsed_us,
    output logic                         empty,
    input  wire                          pop,
    output logic signed [31:0]           o_pose_x,
    output logic signed [31:0]           o_pose_y,
    output logic [15:0]                  o_heading,
    output logic signed [15:0]           o_mean_linear,
    output logic signed [15:0]           o_mean_angular,
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire [1:0]                    i_cfg_index,
    input  wire [odi_pkg::CFG_W-1:0]     i_cfg_data
);
    import odi_pkg::*;

    logic [1:0]       r_mode;
    logic [CNT_W-1:0] r_batch;
    logic [CFG_W-1:0] r_thr;
    logic             q_push, q_full, job_valid, job_pop, res_valid;
    t_job             job_in, job_out;
    t_result          res;
    t_back_stat       stat;

    assign o_cfg_ready    = 1'b1;
    assign full           = q_full;
    assign empty          = !res_valid;
    assign o_pose_x       = res.pose_x;
    assign o_pose_y       = res.pose_y;
    assign o_heading      = res.heading;
    assign o_mean_linear  = res.mean_linear;
    assign o_mean_angular = res.mean_angular;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_EULER;
            r_batch <= CNT_W'(1);
            r_thr   <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_MODE:  r_mode  <= i_cfg_data[1:0];
                CFG_BATCH: r_batch <= i_cfg_data[CNT_W-1:0];
                CFG_THR:   r_thr   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    odi_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_push             (push),
        .i_linear_velocity  (i_linear_velocity),
        .i_angular_velocity (i_angular_velocity),
        .i_elapsed_us       (i_elapsed_us),
        .i_batch_count      (r_batch),
        .i_q_full           (q_full),
        .o_q_push           (q_push),
        .o_job              (job_in)
    );

    odi_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (job_in),
        .o_full  (q_full),
        .i_pop   (job_pop),
        .o_valid (job_valid),
        .o_job   (job_out)
    );

    odi_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job_out),
        .o_job_pop   (job_pop),
        .i_mode      (r_mode),
        .i_threshold (r_thr),
        .i_res_pop   (pop),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_stat      (stat)
    );

`ifndef SYNTHESIS
    a_pop_has_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_pop |-> job_valid)
        else $error("back took a job from an empty queue");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.load |-> (empty || pop))
        else $error("result word overwritten before it was taken");
    a_busy_after_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_pop |=> stat.busy)
        else $error("back idle right after taking a job");
`endif
endmodule
`default_nettype wire
